// File: rtl/orbit_apsides_from_state_unit_defines.svh
// ----------------------------------------------------------------------------
// Orbit apsides unit assertion macros
// Clocked assertion shorthands for the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef ORBIT_APSIDES_FROM_STATE_UNIT_DEFINES_SVH
`define ORBIT_APSIDES_FROM_STATE_UNIT_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define OAS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising clock edge, reset included
`define OAS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/oas_pkg.sv
// ----------------------------------------------------------------------------
// Orbit apsides package
// Types, constants and helper functions shared by the orbit apsides unit.
// ----------------------------------------------------------------------------
`default_nettype none

package oas_pkg;

  localparam logic [30:0] GRAV_RESET   = 31'd398600;
  localparam logic [19:0] RADIUS_RESET = 20'd6378;
  localparam logic [63:0] SAT64        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [30:0] OUT_MAX      = 31'h7FFF_FFFF;
  localparam logic [30:0] NE_APOGEE    = 31'd99999;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    logic    sat;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    abs32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] x);
    abs64 = x[63] ? (~x + 64'd1) : x;
  endfunction

  function automatic logic [30:0] clamp31(input logic signed [65:0] v);
    if (v < 66'sd0) begin
      clamp31 = '0;
    end else if (v > $signed({35'd0, OUT_MAX})) begin
      clamp31 = OUT_MAX;
    end else begin
      clamp31 = v[30:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/orbit_apsides_from_state_unit.sv
// ----------------------------------------------------------------------------
// Orbit apsides from state vector
// Apogee, perigee and period of a two-body orbit from one position and
// velocity sample, worked out on one shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one word holds pos_x..vel_z (32 bits each, pos_x lowest).
//   Output stream: one word per input with apogee, perigee and period.
//   Configuration: cfg_we writes grav_param (index 0) or body_radius
//   (index 1) from cfg_data; write only while the block is idle.
//   Sequencing: a sequencer issues 28 operations to the shared unit, each
//   through an issue and a wait state; a multiply runs until its multiplier
//   is shifted out, a divide through all 64 quotient bits and a square root
//   through every result bit. A non-elliptic orbit stops after the eighth
//   operation.
//   s_axis_tready is high only while no word is in work; one word at a time.
//   The result sits in an output register; the next input word is taken
//   while it waits. If the receiver stalls, the block holds its next
//   result until the output register frees.
//   Reset: synchronous; restores the default gravity and radius and drops
//   any word in work.
// ----------------------------------------------------------------------------
`default_nettype none

`include "orbit_apsides_from_state_unit_defines.svh"

module orbit_apsides_from_state_unit import oas_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  wire logic [191:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // apogee[30:0], perigee[62:31], period_s[93:63], zero pad
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [30:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    SP_RX2, SP_RY2, SP_RZ2, SP_RSQRT,
    SP_VX2, SP_VY2, SP_VZ2, SP_VR, SP_NUM, SP_SEMI,
    SP_HX0, SP_HX1, SP_HY0, SP_HY1, SP_HZ0, SP_HZ1,
    SP_HSX, SP_HSY, SP_HSZ, SP_HQ, SP_EDEN, SP_AA, SP_Q,
    SP_AESQ, SP_AE, SP_AAMU, SP_A3, SP_S
  } step_t;

  state_t      state;
  step_t       step;
  logic [30:0] mu;
  logic [19:0] radius;

  logic [17:0] rmag [3];
  logic        rneg [3];
  logic [23:0] vmag [3];
  logic        vneg [3];

  logic [63:0] acc;
  logic [17:0] rm;
  logic [63:0] vr;
  logic [63:0] a_r;
  logic [63:0] prod0;
  logic [63:0] hx;
  logic [63:0] hy;
  logic [63:0] hz;
  logic [63:0] hq;
  logic [63:0] eden;
  logic [63:0] enum_r;
  logic [63:0] aa;
  logic [63:0] tq;
  logic [31:0] ae;
  logic [31:0] s;
  logic        noell;

  alu_req_t    req;
  alu_stat_t   stat;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] res;
  logic        pneg;

  logic [63:0] sres;
  logic [63:0] eden_w;
  logic [63:0] en_w;
  logic [63:0] mu2;

  logic signed [65:0] apo_w;
  logic signed [65:0] peri_w;
  logic [35:0]        per_w;
  logic [30:0]        apo_o;
  logic [31:0]        peri_o;
  logic [30:0]        per_o;

  oas_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .stat (stat),
    .res  (res)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign mu2           = {32'd0, mu, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      mu     <= GRAV_RESET;
      radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        mu <= cfg_data;
      end else begin
        radius <= cfg_data[19:0];
      end
    end
  end

  always_comb begin
    req.start = (state == ST_ISSUE);
    req.op    = OP_MUL;
    req.sat   = 1'b1;
    opa       = '0;
    opb       = '0;
    pneg      = 1'b0;
    unique case (step)
      SP_RX2: begin
        opa = 64'(rmag[0]);
        opb = 64'(rmag[0]);
      end
      SP_RY2: begin
        opa = 64'(rmag[1]);
        opb = 64'(rmag[1]);
      end
      SP_RZ2: begin
        opa = 64'(rmag[2]);
        opb = 64'(rmag[2]);
      end
      SP_RSQRT: begin
        req.op = OP_SQRT;
        opa    = acc;
      end
      SP_VX2: begin
        opa = 64'(vmag[0]);
        opb = 64'(vmag[0]);
      end
      SP_VY2: begin
        opa = 64'(vmag[1]);
        opb = 64'(vmag[1]);
      end
      SP_VZ2: begin
        opa = 64'(vmag[2]);
        opb = 64'(vmag[2]);
      end
      SP_VR: begin
        opa = acc;
        opb = 64'(rm);
      end
      SP_NUM: begin
        opa = 64'(mu);
        opb = 64'(rm);
      end
      SP_SEMI: begin
        req.op = OP_DIV;
        opa    = acc;
        opb    = mu2 - vr;
      end
      SP_HX0: begin
        opa  = 64'(rmag[1]);
        opb  = 64'(vmag[2]);
        pneg = rneg[1] ^ vneg[2];
      end
      SP_HX1: begin
        opa  = 64'(rmag[2]);
        opb  = 64'(vmag[1]);
        pneg = rneg[2] ^ vneg[1];
      end
      SP_HY0: begin
        opa  = 64'(rmag[2]);
        opb  = 64'(vmag[0]);
        pneg = rneg[2] ^ vneg[0];
      end
      SP_HY1: begin
        opa  = 64'(rmag[0]);
        opb  = 64'(vmag[2]);
        pneg = rneg[0] ^ vneg[2];
      end
      SP_HZ0: begin
        opa  = 64'(rmag[0]);
        opb  = 64'(vmag[1]);
        pneg = rneg[0] ^ vneg[1];
      end
      SP_HZ1: begin
        opa  = 64'(rmag[1]);
        opb  = 64'(vmag[0]);
        pneg = rneg[1] ^ vneg[0];
      end
      SP_HSX: begin
        req.sat = 1'b0;
        opa     = abs64(hx);
        opb     = abs64(hx);
      end
      SP_HSY: begin
        req.sat = 1'b0;
        opa     = abs64(hy);
        opb     = abs64(hy);
      end
      SP_HSZ: begin
        req.sat = 1'b0;
        opa     = abs64(hz);
        opb     = abs64(hz);
      end
      SP_HQ: begin
        req.op = OP_DIV;
        opa    = abs64(acc);
        opb    = 64'(mu);
      end
      SP_EDEN: begin
        opa = 64'(mu);
        opb = a_r;
      end
      SP_AA: begin
        opa = a_r;
        opb = a_r;
      end
      SP_Q: begin
        req.op = OP_DIV;
        opa    = aa;
        opb    = eden;
      end
      SP_AESQ: begin
        opa = tq;
        opb = enum_r;
      end
      SP_AE: begin
        req.op = OP_SQRT;
        opa    = tq;
      end
      SP_AAMU: begin
        req.op = OP_DIV;
        opa    = aa;
        opb    = 64'(mu);
      end
      SP_A3: begin
        opa = tq;
        opb = a_r;
      end
      SP_S: begin
        req.op = OP_SQRT;
        opa    = tq;
      end
      default: opa = '0;
    endcase
  end

  assign sres   = pneg ? (~res + 64'd1) : res;
  assign eden_w = (res == '0) ? 64'd1 : res;
  assign en_w   = eden_w - hq;

  assign apo_w  = $signed({2'b00, a_r}) + $signed({34'd0, ae}) - $signed({46'd0, radius});
  assign peri_w = $signed({2'b00, a_r}) - $signed({34'd0, ae}) - $signed({46'd0, radius});
  assign per_w  = {2'b00, s, 2'b00} + {3'b000, s, 1'b0} + {6'd0, s[31:2]};

  always_comb begin
    if (noell) begin
      apo_o  = NE_APOGEE;
      peri_o = {14'd0, rm} - {12'd0, radius};
      per_o  = '0;
    end else begin
      apo_o  = clamp31(apo_w);
      peri_o = {1'b0, clamp31(peri_w)};
      per_o  = (per_w > {5'd0, OUT_MAX}) ? OUT_MAX : per_w[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= SP_RX2;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          step  <= SP_RX2;
          state <= ST_ISSUE;
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: if (stat.done) begin
          if ((step == SP_VR) && (res >= mu2)) begin
            state <= ST_FINISH;
          end else if (step == SP_S) begin
            state <= ST_FINISH;
          end else begin
            step  <= step_t'(step + 5'd1);
            state <= ST_ISSUE;
          end
        end
        ST_FINISH: if (!m_axis_tvalid || m_axis_tready) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_axis_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        rmag[i] <= 18'(abs32(s_axis_tdata[32*i +: 32]) >> 14);
        rneg[i] <= s_axis_tdata[32*i + 31];
        vmag[i] <= 24'(abs32(s_axis_tdata[32*(i+3) +: 32]) >> 8);
        vneg[i] <= s_axis_tdata[32*(i+3) + 31];
      end
      noell <= 1'b0;
    end
    if ((state == ST_WAIT) && stat.done) begin
      case (step)
        SP_RX2, SP_VX2, SP_NUM, SP_HSX: acc <= res;
        SP_RY2, SP_RZ2, SP_VY2, SP_VZ2, SP_HSY, SP_HSZ: acc <= acc + res;
        SP_RSQRT: rm <= (res == '0) ? 18'd1 : res[17:0];
        SP_VR: begin
          vr    <= res;
          noell <= (res >= mu2);
        end
        SP_SEMI: a_r <= res;
        SP_HX0, SP_HY0, SP_HZ0: prod0 <= sres;
        SP_HX1: hx <= prod0 - sres;
        SP_HY1: hy <= prod0 - sres;
        SP_HZ1: hz <= prod0 - sres;
        SP_HQ: hq <= acc[63] ? (~res + 64'd1) : res;
        SP_EDEN: begin
          eden   <= eden_w;
          enum_r <= en_w[63] ? 64'd0 : en_w;
        end
        SP_AA: aa <= res;
        SP_Q, SP_AESQ, SP_AAMU, SP_A3: tq <= res;
        SP_AE: ae <= res[31:0];
        SP_S: s <= res[31:0];
        default: tq <= tq;
      endcase
    end
    if ((state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {2'b00, per_o, peri_o, apo_o};
    end
  end

  `OAS_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "word in work")
  `OAS_ASSERT(a_done_in_wait, stat.done |-> state == ST_WAIT, "unit finished outside wait")
  `OAS_ASSERT(a_finish_unit_idle, state == ST_FINISH |-> !stat.busy, "unit still busy at finish")

endmodule

`default_nettype wire

// File: rtl/oas_alu.sv
// ----------------------------------------------------------------------------
// Orbit apsides shared arithmetic unit
// Iterative 64-bit unit: shift-add multiply (saturating or wrapping),
// restoring divide and digit-by-digit floor square root, one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oas_alu import oas_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire alu_req_t    req,
  input  wire logic [63:0] opa,
  input  wire logic [63:0] opb,
  output alu_stat_t        stat,
  output logic [63:0]      res
);

  logic        busy;
  logic        done;
  alu_op_t     op_r;
  logic        sat_r;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] z;
  logic        ovf;
  logic        satf;
  logic [5:0]  cnt;

  logic [64:0] msum;
  logic [64:0] dtry;
  logic [63:0] sroot;

  assign msum  = {1'b0, x} + {1'b0, y};
  assign dtry  = {x, y[63]};
  assign sroot = x + z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy) begin
        unique case (op_r)
          OP_MUL:  if (z == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          OP_DIV:  if (cnt == 6'd63) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          OP_SQRT: if (z == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      sat_r <= req.sat;
      x     <= '0;
      y     <= opa;
      z     <= (req.op == OP_SQRT) ? (64'd1 << 62) : opb;
      ovf   <= 1'b0;
      satf  <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      case (op_r)
        OP_MUL: if (z != '0) begin
          if (z[0]) begin
            x <= msum[63:0];
            if (sat_r && (ovf || msum[64] || msum[63])) begin
              satf <= 1'b1;
            end
          end
          y   <= {y[62:0], 1'b0};
          ovf <= ovf | y[63] | y[62];
          z   <= {1'b0, z[63:1]};
        end
        OP_DIV: begin
          if (dtry >= {1'b0, z}) begin
            x <= 64'(dtry - {1'b0, z});
            y <= {y[62:0], 1'b1};
          end else begin
            x <= dtry[63:0];
            y <= {y[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
        end
        OP_SQRT: if (z != '0) begin
          if (y >= sroot) begin
            y <= y - sroot;
            x <= {1'b0, x[63:1]} + z;
          end else begin
            x <= {1'b0, x[63:1]};
          end
          z <= {2'b00, z[63:2]};
        end
        default: x <= x;
      endcase
    end
  end

  always_comb begin
    case (op_r)
      OP_MUL:  res = (sat_r && satf) ? SAT64 : x;
      OP_DIV:  res = y;
      default: res = x;
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire
